>>> hw/rtl/lbp_pkg.sv
`default_nettype none

package lbp_pkg;

   // line store geometry
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);

   // register widths
   localparam int WIDTH_CFG_W  = 11;
   localparam int HEIGHT_CFG_W = 16;
   localparam int OFFSET_W     = 9;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int PIXEL_W      = 8;

   // neighbour compare width: pixel plus signed offset, guard bits
   localparam int CMP_W = PIXEL_W + 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_OFFSET = 2'd2;

   // register reset values
   localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd512;
   localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 16'd512;
   localparam logic [OFFSET_W-1:0]     OFFSET_RESET = 9'd16;

   // smallest frame the window logic handles
   localparam int MIN_DIM = 3;

   // window queue between front and back
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_COUNT_W = $clog2(Q_DEPTH + 2);

   // 3x3 window, index = row * 3 + column, row 0 is the oldest row
   typedef logic [8:0][PIXEL_W-1:0] window_type;

   typedef struct packed {
      window_type window;
      logic       last;
   } win_entry_type;

   typedef struct packed {
      logic          valid;
      win_entry_type entry;
   } q_push_type;

   // front status seen by the top level checks
   typedef struct packed {
      logic col_zero;
      logic row_zero;
   } front_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/lbp_3x3_threshold_unit.sv
// A window passes stage 1, the window queue and the output register before rsp_tvalid.
// Throughput: 1 pixel per cycle; the front stalls only when the 4-entry window queue
//   plus the transaction in the line store read stage would overflow it.
// Border pixels are accepted the same way but give no transaction.
// Reset (synchronous): counters, window, queue and output valid clear; registers go to
//   width 512, height 512, offset 16. Line store contents are not cleared.
`default_nettype none

module lbp_3x3_threshold_unit (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [7:0]                        req_tdata,   // [7:0] pixel
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] pattern_code
   output logic                              rsp_tlast,   // frame_last
   input  wire                               csr_wr_en,
   input  wire  [lbp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [lbp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lbp_pkg::*;

   logic [WIDTH_CFG_W-1:0]  width_ff;
   logic [HEIGHT_CFG_W-1:0] height_ff;
   logic [OFFSET_W-1:0]     offset_ff;

   q_push_type              q_push;
   win_entry_type           head;
   logic                    not_empty;
   logic                    pop;
   logic [Q_COUNT_W-1:0]    q_count;
   front_status_type        status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[WIDTH_CFG_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[HEIGHT_CFG_W-1:0];
            end
            CSR_CENTRE_OFFSET: begin
               offset_ff <= csr_wdata[OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   lbp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .image_width  (width_ff),
      .image_height (height_ff),
      .q_count      (q_count),
      .q_push       (q_push),
      .status       (status)
   );

   lbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (q_count)
   );

   lbp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .not_empty     (not_empty),
      .pop           (pop),
      .centre_offset (offset_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

   // queue takes a push while full only when an entry is popped in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> (q_count < Q_COUNT_W'(Q_DEPTH)) || pop)
      else $error("window queue overflow");

   // fill count stays within the queue depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      q_count <= Q_COUNT_W'(Q_DEPTH))
      else $error("window queue count out of range");

   // the frame's last code leaves the counters back at the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (q_push.valid && q_push.entry.last) |-> (status.col_zero && status.row_zero))
      else $error("frame end without counter wrap");

endmodule

`default_nettype wire

>>> hw/rtl/lbp_front.sv
`default_nettype none

module lbp_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [7:0]                           req_tdata,     // [7:0] pixel
   input  wire  [lbp_pkg::WIDTH_CFG_W-1:0]      image_width,
   input  wire  [lbp_pkg::HEIGHT_CFG_W-1:0]     image_height,
   input  wire  [lbp_pkg::Q_COUNT_W-1:0]        q_count,
   output lbp_pkg::q_push_type                  q_push,
   output lbp_pkg::front_status_type            status
);
   import lbp_pkg::*;

   logic                    accept;
   logic [WIDTH_CFG_W-1:0]  eff_width;
   logic [HEIGHT_CFG_W-1:0] eff_height;
   logic                    row_end;
   logic                    frame_end;
   logic                    emit;
   logic [Q_COUNT_W-1:0]    in_flight;

   logic [COL_W-1:0]        col_ff, col_in;
   logic [HEIGHT_CFG_W-1:0] row_ff, row_in;

   // stage 1 registers
   logic                    s1_valid_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;
   logic [COL_W-1:0]        s1_idx_ff;
   logic [PIXEL_W-1:0]      s1_px_ff;
   logic [2*PIXEL_W-1:0]    rd_ff;

   window_type              window_ff, window_in;

   // line store: [15:8] row two above, [7:0] row one above
   logic [2*PIXEL_W-1:0]    line_mem [MAX_WIDTH];

   // effective frame size
   always_comb begin
      if (image_width < WIDTH_CFG_W'(MIN_DIM)) begin
         eff_width = WIDTH_CFG_W'(MIN_DIM);
      end else if (image_width > WIDTH_CFG_W'(MAX_WIDTH)) begin
         eff_width = WIDTH_CFG_W'(MAX_WIDTH);
      end else begin
         eff_width = image_width;
      end
      eff_height = (image_height < HEIGHT_CFG_W'(MIN_DIM)) ?
                   HEIGHT_CFG_W'(MIN_DIM) : image_height;
   end

   // credit check: queue entries plus the one possibly in stage 1
   assign in_flight  = q_count + Q_COUNT_W'(s1_valid_ff & s1_emit_ff);
   assign req_tready = (in_flight < Q_COUNT_W'(Q_DEPTH));
   assign accept     = req_tvalid & req_tready;

   // position classification
   assign row_end   = ({1'b0, col_ff} + WIDTH_CFG_W'(1)) >= eff_width;
   assign frame_end = row_end &&
                      (({1'b0, row_ff} + 17'd1) >= {1'b0, eff_height});
   assign emit      = (row_ff >= HEIGHT_CFG_W'(2)) && (col_ff >= COL_W'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + HEIGHT_CFG_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   // stage 1 payload and line store read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit;
         s1_last_ff <= frame_end;
         s1_idx_ff  <= col_ff;
         s1_px_ff   <= req_tdata;
         rd_ff      <= line_mem[col_ff];
      end
   end

   // line store write: row one above moves to row two above
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_idx_ff] <= {rd_ff[PIXEL_W-1:0], s1_px_ff};
      end
   end

   // window shift, new column enters on the right
   always_comb begin
      window_in = window_ff;
      if (s1_valid_ff) begin
         window_in[0] = window_ff[1];
         window_in[1] = window_ff[2];
         window_in[2] = rd_ff[2*PIXEL_W-1:PIXEL_W];
         window_in[3] = window_ff[4];
         window_in[4] = window_ff[5];
         window_in[5] = rd_ff[PIXEL_W-1:0];
         window_in[6] = window_ff[7];
         window_in[7] = window_ff[8];
         window_in[8] = s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // interior positions go to the queue
   assign q_push.valid        = s1_valid_ff & s1_emit_ff;
   assign q_push.entry.window = window_in;
   assign q_push.entry.last   = s1_last_ff;

   assign status.col_zero = (col_ff == '0);
   assign status.row_zero = (row_ff == '0);

endmodule

`default_nettype wire

>>> hw/rtl/lbp_queue.sv
`default_nettype none

module lbp_queue (
   input  wire                           clock,
   input  wire                           reset,
   input  lbp_pkg::q_push_type           q_push,
   input  wire                           pop,
   output lbp_pkg::win_entry_type        head,
   output logic                          not_empty,
   output logic [lbp_pkg::Q_COUNT_W-1:0] count
);
   import lbp_pkg::*;

   win_entry_type          slots_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_COUNT_W-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign not_empty = (count_ff != '0);
   assign do_pop    = pop & not_empty;
   assign head      = slots_ff[rd_ptr_ff];
   assign count     = count_ff;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = q_push.valid ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_COUNT_W'(q_push.valid) - Q_COUNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         slots_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/lbp_back.sv
`default_nettype none

module lbp_back (
   input  wire                             clock,
   input  wire                             reset,
   input  lbp_pkg::win_entry_type          head,
   input  wire                             not_empty,
   output logic                            pop,
   input  wire  [lbp_pkg::OFFSET_W-1:0]    centre_offset,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [7:0]                      rsp_tdata,    // [7:0] pattern_code
   output logic                            rsp_tlast     // frame_last
);
   import lbp_pkg::*;

   logic signed [CMP_W-1:0] centre;
   logic [7:0]              code;
   logic                    rsp_valid_ff;
   logic [7:0]              code_ff;
   logic                    last_ff;

   function automatic logic ge_centre(input logic [PIXEL_W-1:0] nb,
                                      input logic signed [CMP_W-1:0] c);
      logic signed [CMP_W-1:0] nb_s;
      nb_s = signed'({3'b000, nb});
      return nb_s >= c;
   endfunction

   // threshold = centre pixel + signed offset
   assign centre = signed'({3'b000, head.window[4]}) +
                   CMP_W'(signed'(centre_offset));

   // bits clockwise from the top-left neighbour
   always_comb begin
      code[7] = ge_centre(head.window[0], centre);
      code[6] = ge_centre(head.window[1], centre);
      code[5] = ge_centre(head.window[2], centre);
      code[4] = ge_centre(head.window[5], centre);
      code[3] = ge_centre(head.window[8], centre);
      code[2] = ge_centre(head.window[7], centre);
      code[1] = ge_centre(head.window[6], centre);
      code[0] = ge_centre(head.window[3], centre);
   end

   // output register, refilled when empty or being taken
   assign pop = not_empty & (~rsp_valid_ff | rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (~rsp_valid_ff | rsp_tready) begin
         rsp_valid_ff <= not_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         code_ff <= code;
         last_ff <= head.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = code_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire
